FILE: rtl/chi_pkg.sv
`default_nettype none

package chi_pkg;

    localparam int MAX_TABLES      = 4;
    localparam int SLOTS_PER_TABLE = 1024;
    localparam int KICK_LIMIT      = 64;

    localparam int KEY_W    = 31;
    localparam int SIZE_W   = 11;
    localparam int SLOT_W   = $clog2(SLOTS_PER_TABLE);
    localparam int TAB_W    = $clog2(MAX_TABLES);
    localparam int NTAB_W   = 3;
    localparam int KICK_W   = 7;
    localparam int STATUS_W = 2;
    localparam int BIT_W    = $clog2(KEY_W);
    localparam int ADDR_W   = TAB_W + SLOT_W;
    localparam int DEPTH    = MAX_TABLES * SLOTS_PER_TABLE;
    localparam int MOD_W    = SIZE_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 31;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_PLACED  = 2'd0,
        STATUS_DROPPED = 2'd1,
        STATUS_READ    = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TABLE_SIZE    = 3'd0,
        REG_TABLES_IN_USE = 3'd1,
        REG_MAX_KICKS     = 3'd2,
        REG_MULT_0        = 3'd3,
        REG_MULT_1        = 3'd4,
        REG_MULT_2        = 3'd5,
        REG_MULT_3        = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_HASH_M,
        ST_HASH_K,
        ST_MEM_ADDR,
        ST_MEM_DATA,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/chi_ram.sv
`default_nettype none

module chi_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/cuckoo_hash_insert_core.sv
`default_nettype none
// Read request: the result passes states RD_ADDR, RD_DATA and FINISH before it is presented.
// Insert request: each placement attempt is a bit-serial hash (multiplier, then key), then a
// registered slot read; up to max_kicks attempts. One request at a time.
// Zero-key insert: reported as placed without a slot store access.
// After reset all 4096 slots of the store are cleared; no request is taken meanwhile.
// Registers return to their documented reset values on rst_n low.

module cuckoo_hash_insert_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // key [30:0], table_index [32:31], slot_index [42:33], zero fill
    input  wire logic [chi_pkg::S_DATA_W-1:0]   s_tdata,
    // command
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // key_out [30:0], kick_count [37:31], zero fill
    output logic      [chi_pkg::M_DATA_W-1:0]   m_tdata,
    // status
    output logic      [chi_pkg::STATUS_W-1:0]   m_tuser,
    input  wire logic                           cfg_we,
    input  wire logic [chi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [chi_pkg::CFG_W-1:0]      cfg_wdata
);

    import chi_pkg::*;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] table_size_reg;
    logic [NTAB_W-1:0] tables_in_use_reg;
    logic [KICK_W-1:0] max_kicks_reg;
    logic [KEY_W-1:0]  mult_reg [MAX_TABLES];

    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [KEY_W-1:0]    carry_reg, carry_next;
    logic [TAB_W-1:0]    table_reg, table_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    logic [SLOT_W-1:0]   r_reg, r_next;
    logic [SLOT_W-1:0]   mmod_reg, mmod_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [KICK_W-1:0]   attempt_reg, attempt_next;
    logic [KICK_W-1:0]   kicks_reg, kicks_next;
    status_t             res_status_reg, res_status_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [KICK_W-1:0]   res_kicks_reg, res_kicks_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [KEY_W-1:0]    out_key_reg, out_key_next;
    logic [KICK_W-1:0]   out_kicks_reg, out_kicks_next;

    logic [SIZE_W-1:0] size_eff;
    logic [NTAB_W-1:0] ntab_eff;
    logic [KICK_W-1:0] limit_eff;
    logic [KEY_W-1:0]  mult_sel;
    logic [MOD_W-1:0]  addend;
    logic [MOD_W-1:0]  mod_sum;
    logic [MOD_W-1:0]  mod_out;
    logic [MOD_W-1:0]  size1;
    logic [MOD_W-1:0]  size2;
    logic [NTAB_W-1:0] table_inc;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [KEY_W-1:0]  ram_rdata;

    logic [KEY_W-1:0]  in_key;
    logic [TAB_W-1:0]  in_table;
    logic [SLOT_W-1:0] in_slot;

    assign in_key   = s_tdata[KEY_W-1:0];
    assign in_table = s_tdata[KEY_W +: TAB_W];
    assign in_slot  = s_tdata[KEY_W+TAB_W +: SLOT_W];

    always_comb
    begin
        if (table_size_reg == '0)
            size_eff = SIZE_W'(1);
        else if (table_size_reg > SIZE_W'(SLOTS_PER_TABLE))
            size_eff = SIZE_W'(SLOTS_PER_TABLE);
        else
            size_eff = table_size_reg;

        if (tables_in_use_reg == '0)
            ntab_eff = NTAB_W'(1);
        else if (tables_in_use_reg > NTAB_W'(MAX_TABLES))
            ntab_eff = NTAB_W'(MAX_TABLES);
        else
            ntab_eff = tables_in_use_reg;

        if (max_kicks_reg == '0)
            limit_eff = KICK_W'(1);
        else if (max_kicks_reg > KICK_W'(KICK_LIMIT))
            limit_eff = KICK_W'(KICK_LIMIT);
        else
            limit_eff = max_kicks_reg;
    end

    assign mult_sel  = mult_reg[table_reg];
    assign table_inc = NTAB_W'(table_reg) + NTAB_W'(1);

    // shared modular step: r <- (2r + addend) mod size
    always_comb
    begin
        if (state_reg == ST_HASH_K)
            addend = carry_reg[bit_reg] ? MOD_W'(mmod_reg) : '0;
        else
            addend = MOD_W'(mult_sel[bit_reg]);
        size1   = MOD_W'(size_eff);
        size2   = {size_eff, 1'b0};
        mod_sum = MOD_W'({r_reg, 1'b0}) + addend;
        if (mod_sum >= size2)
            mod_out = mod_sum - size2;
        else if (mod_sum >= size1)
            mod_out = mod_sum - size1;
        else
            mod_out = mod_sum;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        m_tvalid_next   = m_tvalid_reg & ~m_tready;
        carry_next      = carry_reg;
        table_next      = table_reg;
        pos_next        = pos_reg;
        r_next          = r_reg;
        mmod_next       = mmod_reg;
        bit_next        = bit_reg;
        attempt_next    = attempt_reg;
        kicks_next      = kicks_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_kicks_next  = res_kicks_reg;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_kicks_next  = out_kicks_reg;
        ram_we          = 1'b0;
        ram_waddr       = {table_reg, pos_reg};
        ram_wdata       = carry_reg;
        s_tready        = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == CMD_READ)
                    begin
                        table_next = in_table;
                        pos_next   = in_slot;
                        state_next = ST_RD_ADDR;
                    end
                    else if (in_key == '0)
                    begin
                        res_status_next = STATUS_PLACED;
                        res_key_next    = '0;
                        res_kicks_next  = '0;
                        state_next      = ST_FINISH;
                    end
                    else
                    begin
                        carry_next   = in_key;
                        table_next   = '0;
                        r_next       = '0;
                        bit_next     = BIT_W'(KEY_W - 1);
                        kicks_next   = '0;
                        attempt_next = KICK_W'(1);
                        state_next   = ST_HASH_M;
                    end
                end
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                res_status_next = STATUS_READ;
                res_key_next    = ram_rdata;
                res_kicks_next  = '0;
                state_next      = ST_FINISH;
            end
            ST_HASH_M:
            begin
                r_next   = mod_out[SLOT_W-1:0];
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0)
                begin
                    mmod_next  = mod_out[SLOT_W-1:0];
                    r_next     = '0;
                    bit_next   = BIT_W'(KEY_W - 1);
                    state_next = ST_HASH_K;
                end
            end
            ST_HASH_K:
            begin
                r_next   = mod_out[SLOT_W-1:0];
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0)
                begin
                    pos_next   = mod_out[SLOT_W-1:0];
                    state_next = ST_MEM_ADDR;
                end
            end
            ST_MEM_ADDR:
            begin
                state_next = ST_MEM_DATA;
            end
            ST_MEM_DATA:
            begin
                if (ram_rdata == '0)
                begin
                    ram_we          = 1'b1;
                    res_status_next = STATUS_PLACED;
                    res_key_next    = '0;
                    res_kicks_next  = kicks_reg;
                    state_next      = ST_FINISH;
                end
                else if (attempt_reg == limit_eff)
                begin
                    res_status_next = STATUS_DROPPED;
                    res_key_next    = carry_reg;
                    res_kicks_next  = kicks_reg;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    ram_we       = 1'b1;
                    carry_next   = ram_rdata;
                    kicks_next   = kicks_reg + KICK_W'(1);
                    attempt_next = attempt_reg + KICK_W'(1);
                    if (table_inc >= ntab_eff)
                        table_next = '0;
                    else
                        table_next = table_inc[TAB_W-1:0];
                    r_next       = '0;
                    bit_next     = BIT_W'(KEY_W - 1);
                    state_next   = ST_HASH_M;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = res_status_reg;
                    out_key_next    = res_key_reg;
                    out_kicks_next  = res_kicks_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg    <= SIZE_W'(1024);
            tables_in_use_reg <= NTAB_W'(2);
            max_kicks_reg     <= KICK_W'(3);
            mult_reg[0]       <= KEY_W'(2);
            mult_reg[1]       <= KEY_W'(6);
            mult_reg[2]       <= KEY_W'(1);
            mult_reg[3]       <= KEY_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TABLE_SIZE:    table_size_reg    <= cfg_wdata[SIZE_W-1:0];
                REG_TABLES_IN_USE: tables_in_use_reg <= cfg_wdata[NTAB_W-1:0];
                REG_MAX_KICKS:     max_kicks_reg     <= cfg_wdata[KICK_W-1:0];
                REG_MULT_0:        mult_reg[0]       <= cfg_wdata[KEY_W-1:0];
                REG_MULT_1:        mult_reg[1]       <= cfg_wdata[KEY_W-1:0];
                REG_MULT_2:        mult_reg[2]       <= cfg_wdata[KEY_W-1:0];
                REG_MULT_3:        mult_reg[3]       <= cfg_wdata[KEY_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg      <= carry_next;
        table_reg      <= table_next;
        pos_reg        <= pos_next;
        r_reg          <= r_next;
        mmod_reg       <= mmod_next;
        bit_reg        <= bit_next;
        attempt_reg    <= attempt_next;
        kicks_reg      <= kicks_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_kicks_reg  <= res_kicks_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_kicks_reg  <= out_kicks_next;
    end

    chi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr ({table_reg, pos_reg}),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_DATA_W - KEY_W - KICK_W){1'b0}}, out_kicks_reg, out_key_reg};

endmodule

`default_nettype wire
